// ===== rtl/caf_pkg.sv =====
// shared types, constants and fixed-point helpers for the anisotropy field block
`default_nettype none
package caf_pkg;

  localparam int unsigned AxisW = 16;
  localparam int unsigned MagW  = 32;
  localparam int unsigned WordW = 32;
  localparam int unsigned SumW  = 64;
  localparam int unsigned AvgW  = 48;
  localparam int unsigned CfgW  = 64;
  localparam int unsigned IdxW  = 3;

  // register indexes
  localparam logic [IdxW-1:0] RegMeshMode = 3'd0;
  localparam logic [IdxW-1:0] RegAxisOne  = 3'd1;
  localparam logic [IdxW-1:0] RegAxisTwo  = 3'd2;
  localparam logic [IdxW-1:0] RegInvSat   = 3'd3;
  localparam logic [IdxW-1:0] RegGain     = 3'd4;
  localparam logic [IdxW-1:0] RegK1       = 3'd5;
  localparam logic [IdxW-1:0] RegK2       = 3'd6;

  typedef logic signed [AxisW-1:0] axis_t;
  typedef logic signed [WordW-1:0] word_t;

  // settings shared by every lane
  typedef struct packed {
    axis_t [2:0][2:0] e;   // e[axis][component]
    word_t            k1;
    word_t            k2;
  } lane_cfg_t;

  // saturate a 64-bit signed value to int32
  function automatic word_t sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Q2.30 product, floor shift by 30, saturated
  function automatic word_t mulq(input word_t a, input word_t b);
    logic signed [63:0] p;
    p = a * b;
    return sat32(p >>> 30);
  endfunction

  // saturating 32-bit add
  function automatic word_t addq(input word_t a, input word_t b);
    logic signed [63:0] s;
    s = 64'(a) + 64'(b);
    return sat32(s);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/caf_lane.sv =====
// one sublattice lane: projection, cubic terms, fields and energy over a short pipeline
`default_nettype none
module caf_lane
  import caf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              step_i,      // advance the lane
  input  wire lane_cfg_t         cfg_i,
  input  wire logic [31:0]       inv_i,
  input  wire word_t             gain_i,
  input  wire word_t [2:0]       mag_i,
  output word_t [2:0]            field_o,
  output logic signed [63:0]     energy_o
);

  // stage 1: dot products
  logic signed [63:0] dot_q [3], dot_d [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dot_d[i] = 64'(mag_i[0] * cfg_i.e[i][0]) + 64'(mag_i[1] * cfg_i.e[i][1])
               + 64'(mag_i[2] * cfg_i.e[i][2]);
    end
  end

  // stage 2: magnitude times reciprocal, split into two 32x32 products
  logic        neg_q [3];
  logic [63:0] plo_q [3];
  logic [63:0] phi_q [3];
  // stage 3: normalized projections
  word_t d_q [3], d_d [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [63:0] r;
      r = 64'd0;
      if (phi_q[i] >= 64'd32768) r = 64'h7fffffff;
      else begin
        r = (phi_q[i] << 16) + (plo_q[i] >> 16);
        if (r > 64'h7fffffff) r = 64'h7fffffff;
      end
      d_d[i] = neg_q[i] ? -word_t'(r[31:0]) : word_t'(r[31:0]);
    end
  end

  // stage 4: squares and pair products
  word_t sq_q [3], d01_q;
  word_t dd_q [3];
  // stage 5
  word_t a_q [3], d123_q, sqp_q [3];
  word_t dr_q [3];
  // stage 6
  word_t b1_q [3], e2_q, e1_q;
  word_t ar_q [3], bm_q [3];
  // stage 7
  word_t b_q [3], ta_q [3], e1r_q, e2r_q;
  // stage 8
  word_t tb_q [3], ta2_q [3];
  word_t c1_q, c2_q;
  logic signed [63:0] en_q;
  // stage 9 results
  word_t h_q [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      field_o[c] = h_q[c];
    end
  end
  assign energy_o = en_q;

  // pipeline registers
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      for (int i = 0; i < 3; i++) begin
        dot_q[i] <= dot_d[i];
        neg_q[i] <= dot_q[i][63];
        begin
          logic [63:0] mg;
          mg = dot_q[i][63] ? 64'(-dot_q[i]) : 64'(dot_q[i]);
          plo_q[i] <= mg[31:0] * inv_i;
          phi_q[i] <= mg[63:32] * inv_i;
        end
        d_q[i]  <= d_d[i];
        sq_q[i] <= mulq(d_q[i], d_q[i]);
        dd_q[i] <= d_q[i];
        dr_q[i] <= dd_q[i];
      end
      d01_q <= mulq(d_q[0], d_q[1]);
      // stage 5
      a_q[0] <= mulq(dd_q[0], addq(sq_q[1], sq_q[2]));
      a_q[1] <= mulq(dd_q[1], addq(sq_q[0], sq_q[2]));
      a_q[2] <= mulq(dd_q[2], addq(sq_q[0], sq_q[1]));
      d123_q <= mulq(d01_q, dd_q[2]);
      sqp_q[0] <= mulq(sq_q[0], sq_q[1]);
      sqp_q[1] <= mulq(sq_q[0], sq_q[2]);
      sqp_q[2] <= mulq(sq_q[1], sq_q[2]);
      // stage 6
      b1_q[0] <= mulq(d123_q, dr_q[1]);
      b1_q[1] <= mulq(d123_q, dr_q[0]);
      b1_q[2] <= mulq(d123_q, dr_q[0]);
      bm_q[0] <= dr_q[2];
      bm_q[1] <= dr_q[2];
      bm_q[2] <= dr_q[1];
      e2_q <= mulq(d123_q, d123_q);
      e1_q <= addq(addq(sqp_q[0], sqp_q[1]), sqp_q[2]);
      for (int i = 0; i < 3; i++) ar_q[i] <= a_q[i];
      // stage 7
      for (int i = 0; i < 3; i++) b_q[i] <= mulq(b1_q[i], bm_q[i]);
      for (int c = 0; c < 3; c++) begin
        logic signed [63:0] s;
        s = 64'(cfg_i.e[0][c] * ar_q[0]) + 64'(cfg_i.e[1][c] * ar_q[1])
          + 64'(cfg_i.e[2][c] * ar_q[2]);
        ta_q[c] <= sat32(s >>> 14);
      end
      e1r_q <= e1_q;
      e2r_q <= e2_q;
      // stage 8
      for (int c = 0; c < 3; c++) begin
        logic signed [63:0] s;
        s = 64'(cfg_i.e[0][c] * b_q[0]) + 64'(cfg_i.e[1][c] * b_q[1])
          + 64'(cfg_i.e[2][c] * b_q[2]);
        tb_q[c]  <= sat32(s >>> 14);
        ta2_q[c] <= ta_q[c];
      end
      begin
        logic signed [63:0] p1, p2, q1, q2;
        p1 = cfg_i.k1 * gain_i;
        p2 = cfg_i.k2 * gain_i;
        c1_q <= sat32(p1 >>> 16);
        c2_q <= sat32(p2 >>> 16);
        q1 = cfg_i.k1 * e1r_q;
        q2 = cfg_i.k2 * e2r_q;
        en_q <= (q1 >>> 30) + (q2 >>> 30);
      end
      // stage 9
      for (int c = 0; c < 3; c++) begin
        logic signed [63:0] x, y;
        x = c1_q * ta2_q[c];
        y = c2_q * tb_q[c];
        h_q[c] <= sat32((x >>> 30) + (y >>> 30));
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/caf_divider.sv =====
// restoring divider for the sweep average, one quotient bit per cycle
`default_nettype none
module caf_divider
  import caf_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic signed [SumW-1:0] num_i,
  input  wire logic [COUNT_BITS-1:0]  den_i,
  output logic                        busy_o,
  output logic signed [AvgW-1:0]      avg_o
);

  localparam int unsigned CntW = $clog2(SumW + 1);

  logic [SumW-1:0]       rem_q, quo_q;
  logic [COUNT_BITS-1:0] den_q;
  logic                  neg_q;
  logic [CntW-1:0]       cnt_q;
  logic [SumW:0]         trial;
  logic [SumW-1:0]       rem_sh;

  assign rem_sh = {rem_q[SumW-2:0], quo_q[SumW-1]};
  assign trial  = {1'b0, rem_sh} - {{(SumW + 1 - COUNT_BITS){1'b0}}, den_q};

  // control: bit counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(SumW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end
  assign busy_o = (cnt_q != '0);

  // datapath: shift and subtract
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i[SumW-1] ? SumW'(-num_i) : SumW'(num_i);
      den_q <= den_i;
      neg_q <= num_i[SumW-1];
    end else if (cnt_q != '0) begin
      if (!trial[SumW]) begin
        rem_q <= trial[SumW-1:0];
        quo_q <= {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[SumW-2:0], 1'b0};
      end
    end
  end

  // sign and 48-bit saturation
  always_comb begin
    logic [SumW:0] mag;
    mag = {1'b0, quo_q};
    if (neg_q) begin
      if (mag > (65'd1 << (AvgW - 1))) avg_o = {1'b1, {(AvgW - 1){1'b0}}};
      else avg_o = AvgW'(-mag);
    end else begin
      if (mag > ((65'd1 << (AvgW - 1)) - 65'd1)) avg_o = {1'b0, {(AvgW - 1){1'b1}}};
      else avg_o = AvgW'(mag);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cubic_anisotropy_field_core.sv =====
// top level: config registers, two sublattice lanes, energy merge and output register
//
// Cells enter on the in_valid_i/in_ready_o channel, one word per cell, and one
// result word leaves on out_valid_o/out_ready_i for every cell taken.
// The user writes configuration through cfg_we_i/cfg_idx_i/cfg_data_i only
// while idle; the block does not enforce this. One cell is in flight at a
// time. A cell passes the lanes' 9 pipeline stages (sublattice A and B run
// side by side), then the fields are captured and the energy merges into
// the sweep sum. A last cell with counted cells then runs the 64-step
// restoring divider for the average. Its word then goes into the output
// register, and the next cell is taken only once that word is loaded.
// A stalled receiver keeps its word in the output register; the next cell
// still runs, and its word waits in the field capture registers until the
// output register frees. Reset clears the configuration and control
// registers, the energy sum and the cell count; the first cell may be taken right after reset.
`default_nettype none
module cubic_anisotropy_field_core
  import caf_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [IdxW-1:0]      cfg_idx_i,
  input  wire logic [CfgW-1:0]      cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic signed [31:0]   mag_a_x_i,
  input  wire logic signed [31:0]   mag_a_y_i,
  input  wire logic signed [31:0]   mag_a_z_i,
  input  wire logic signed [31:0]   mag_b_x_i,
  input  wire logic signed [31:0]   mag_b_y_i,
  input  wire logic signed [31:0]   mag_b_z_i,
  input  wire logic                 cell_empty_i,
  input  wire logic                 last_cell_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic signed [31:0]        field_a_x_o,
  output logic signed [31:0]        field_a_y_o,
  output logic signed [31:0]        field_a_z_o,
  output logic signed [31:0]        field_b_x_o,
  output logic signed [31:0]        field_b_y_o,
  output logic signed [31:0]        field_b_z_o,
  output logic signed [AvgW-1:0]    average_energy_o,
  output logic                      energy_valid_o
);

  localparam int unsigned LaneLat = 9;
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLane = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  // configuration registers
  logic        mode_q;
  logic [47:0] ax1_q, ax2_q;
  logic [63:0] inv_q, gain_q;
  word_t       k1_q, k2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      ax1_q  <= '0;
      ax2_q  <= '0;
      inv_q  <= '0;
      gain_q <= '0;
      k1_q   <= '0;
      k2_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMeshMode: mode_q <= cfg_data_i[0];
        RegAxisOne:  ax1_q  <= cfg_data_i[47:0];
        RegAxisTwo:  ax2_q  <= cfg_data_i[47:0];
        RegInvSat:   inv_q  <= cfg_data_i;
        RegGain:     gain_q <= cfg_data_i;
        RegK1:       k1_q   <= cfg_data_i[31:0];
        RegK2:       k2_q   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // third axis as cross product, floor shift and saturate to Q1.14
  lane_cfg_t lcfg;
  always_comb begin
    logic signed [47:0] cr [3];
    for (int i = 0; i < 3; i++) begin
      lcfg.e[0][i] = ax1_q[16*i +: 16];
      lcfg.e[1][i] = ax2_q[16*i +: 16];
    end
    cr[0] = 48'(lcfg.e[0][1] * lcfg.e[1][2]) - 48'(lcfg.e[0][2] * lcfg.e[1][1]);
    cr[1] = 48'(lcfg.e[0][2] * lcfg.e[1][0]) - 48'(lcfg.e[0][0] * lcfg.e[1][2]);
    cr[2] = 48'(lcfg.e[0][0] * lcfg.e[1][1]) - 48'(lcfg.e[0][1] * lcfg.e[1][0]);
    for (int i = 0; i < 3; i++) begin
      logic signed [47:0] s;
      s = cr[i] >>> 14;
      if (s > 48'sd32767) lcfg.e[2][i] = 16'sh7fff;
      else if (s < -48'sd32768) lcfg.e[2][i] = 16'sh8000;
      else lcfg.e[2][i] = s[15:0];
    end
    lcfg.k1 = k1_q;
    lcfg.k2 = k2_q;
  end

  // captured input word
  word_t [2:0] ma_q, mb_q;
  logic        empty_q, last_q;

  // control
  logic [1:0] st_q;
  logic [3:0] lat_q;
  logic       div_start, div_busy;
  logic       accept;
  logic       out_load;

  assign in_ready_o = (st_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = (st_q == StOut) && (!out_valid_o || out_ready_i);

  // lanes
  word_t [2:0]        ha, hb;
  logic signed [63:0] ena, enb;

  caf_lane u_lane_a (
    .clk_i    (clk_i),
    .step_i   (1'b1),
    .cfg_i    (lcfg),
    .inv_i    (inv_q[31:0]),
    .gain_i   (gain_q[31:0]),
    .mag_i    (ma_q),
    .field_o  (ha),
    .energy_o (ena)
  );

  caf_lane u_lane_b (
    .clk_i    (clk_i),
    .step_i   (1'b1),
    .cfg_i    (lcfg),
    .inv_i    (inv_q[63:32]),
    .gain_i   (gain_q[63:32]),
    .mag_i    (mb_q),
    .field_o  (hb),
    .energy_o (enb)
  );

  // merge the sublattices' energy: average of A and B in mesh mode 1, A alone otherwise
  logic signed [63:0] en_cell;
  always_comb begin
    logic signed [64:0] t;
    t = 65'(ena) + 65'(enb);
    en_cell = mode_q ? 64'(t >>> 1) : ena;
  end

  // saturating sweep sum and count
  logic signed [SumW-1:0]  sum_q;
  logic [COUNT_BITS-1:0]   cnt_q;
  logic signed [SumW-1:0]  sum_n;
  logic [COUNT_BITS-1:0]   cnt_n;
  always_comb begin
    logic signed [SumW:0] s;
    s = 65'(sum_q) + 65'(en_cell);
    if (empty_q) begin
      sum_n = sum_q;
      cnt_n = cnt_q;
    end else begin
      if (s > 65'sh0_7fff_ffff_ffff_ffff) sum_n = 64'sh7fff_ffff_ffff_ffff;
      else if (s < -65'sh0_8000_0000_0000_0000) sum_n = 64'sh8000_0000_0000_0000;
      else sum_n = s[SumW-1:0];
      cnt_n = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
    end
  end

  assign div_start = (st_q == StLane) && (lat_q == '0) && last_q && (cnt_n != '0);

  logic signed [AvgW-1:0] avg_div;
  logic                   div_used_q;

  caf_divider #(.COUNT_BITS(COUNT_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sum_n),
    .den_i   (cnt_n),
    .busy_o  (div_busy),
    .avg_o   (avg_div)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      lat_q       <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_o <= 1'b0;
      div_used_q  <= 1'b0;
    end else begin
      if (out_load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
      unique case (st_q)
        StIdle: begin
          if (accept) begin
            st_q  <= StLane;
            lat_q <= 4'(LaneLat);
          end
        end
        StLane: begin
          if (lat_q != '0) lat_q <= lat_q - 1'b1;
          else begin
            if (last_q) begin
              sum_q <= '0;
              cnt_q <= '0;
            end else begin
              sum_q <= sum_n;
              cnt_q <= cnt_n;
            end
            div_used_q <= div_start;
            st_q <= div_start ? StDiv : StOut;
          end
        end
        StDiv: begin
          if (!div_busy) st_q <= StOut;
        end
        StOut: begin
          if (out_load) st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  // input capture; B inputs are captured in every mode
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ma_q    <= {mag_a_z_i, mag_a_y_i, mag_a_x_i};
      mb_q    <= {mag_b_z_i, mag_b_y_i, mag_b_x_i};
      empty_q <= cell_empty_i;
      last_q  <= last_cell_i;
    end
  end

  // field capture from the lanes
  word_t [2:0] hfa_q, hfb_q;
  always_ff @(posedge clk_i) begin
    if (st_q == StLane && lat_q == '0) begin
      for (int c = 0; c < 3; c++) begin
        hfa_q[c] <= empty_q ? '0 : ha[c];
        hfb_q[c] <= (empty_q || !mode_q) ? '0 : hb[c];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      field_a_x_o      <= hfa_q[0];
      field_a_y_o      <= hfa_q[1];
      field_a_z_o      <= hfa_q[2];
      field_b_x_o      <= hfb_q[0];
      field_b_y_o      <= hfb_q[1];
      field_b_z_o      <= hfb_q[2];
      average_energy_o <= div_used_q ? avg_div : '0;
      energy_valid_o   <= last_q;
    end
  end

endmodule
`default_nettype wire
